// ===== sv/dsq_pkg.sv =====
// shared types, constants and codes for the deadline sleep queue
package dsq_pkg;

  localparam int DL_W        = 64;
  localparam int DUR_W       = 32;
  localparam int PRI_W       = 6;
  localparam int TID_W       = 8;
  localparam int MAX_RESULTS = 16;
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

  typedef logic [DL_W-1:0] deadline_t;

  // saturation value for deadlines
  localparam deadline_t DL_MAX = '1;

  // input action codes
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_SLEEP = 1'b1;

  // result event codes
  localparam logic EV_WOKEN  = 1'b0;
  localparam logic EV_REJECT = 1'b1;

  typedef struct packed {
    deadline_t          deadline;
    logic [PRI_W-1:0]   prio;
    logic [TID_W-1:0]   owner;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_TCK_RD,
    ST_TCK_CMP,
    ST_TCK_FIN,
    ST_REJ
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic rd_head;
    logic wr_en;
    logic wr_new;
    logic walk_dec;
    logic count_inc;
    logic pop;
    logic push;
    logic push_rej;
    logic push_last;
    logic pend_load;
    logic pend_clear;
  } dsq_cmd_t;

  typedef struct packed {
    logic is_sleep;
    logic dur_zero;
    logic full;
    logic walk_zero;
    logic goes_before;
    logic due;
    logic pend_valid;
    logic out_free;
    logic tick_stop;
  } dsq_sts_t;

endpackage

// ===== sv/dsq_ifs.sv =====
// request and response channel interfaces
interface dsq_req_if;
  import dsq_pkg::*;
  logic               valid;
  logic               ready;
  logic               action;
  logic [DUR_W-1:0]   sleep_ticks;
  logic [PRI_W-1:0]   priority_req;
  logic [TID_W-1:0]   thread_id;
  modport source (output valid, action, sleep_ticks, priority_req, thread_id, input ready);
  modport sink (input valid, action, sleep_ticks, priority_req, thread_id, output ready);
endinterface

interface dsq_rsp_if;
  import dsq_pkg::*;
  logic               valid;
  logic               ready;
  logic               event_res;
  logic [TID_W-1:0]   woken_id;
  logic               last;
  modport source (output valid, event_res, woken_id, last, input ready);
  modport sink (input valid, event_res, woken_id, last, output ready);
endinterface

// ===== sv/dsq_ctrl.sv =====
// sequencer for insert walks, tick releases and result pushes
module dsq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dsq_pkg::dsq_sts_t sts,
  output dsq_pkg::dsq_cmd_t cmd
);
  import dsq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (!sts.is_sleep) begin
            state_next = ST_TCK_RD;
          end else if (sts.dur_zero) begin
            state_next = ST_IDLE;
          end else if (sts.full) begin
            state_next = ST_REJ;
          end else begin
            state_next = ST_INS_RD;
          end
        end
      end
      ST_INS_RD: begin
        if (sts.walk_zero) begin
          cmd.wr_en     = 1'b1;
          cmd.wr_new    = 1'b1;
          cmd.count_inc = 1'b1;
          state_next    = ST_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        // shift the older entry up one slot, or drop the new item here
        if (sts.goes_before) begin
          cmd.wr_en    = 1'b1;
          cmd.walk_dec = 1'b1;
          state_next   = ST_INS_RD;
        end else begin
          cmd.wr_en     = 1'b1;
          cmd.wr_new    = 1'b1;
          cmd.count_inc = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_TCK_RD: begin
        if (sts.tick_stop) begin
          state_next = ST_TCK_FIN;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_head = 1'b1;
          state_next  = ST_TCK_CMP;
        end
      end
      ST_TCK_CMP: begin
        if (!sts.due) begin
          state_next = ST_TCK_FIN;
        end else if (!sts.pend_valid || sts.out_free) begin
          // the held release is not the last one, send it
          cmd.push      = sts.pend_valid;
          cmd.pend_load = 1'b1;
          cmd.pop       = 1'b1;
          state_next    = ST_TCK_RD;
        end
      end
      ST_TCK_FIN: begin
        if (!sts.pend_valid) begin
          state_next = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.push       = 1'b1;
          cmd.push_last  = 1'b1;
          cmd.pend_clear = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_REJ: begin
        if (sts.out_free) begin
          cmd.push      = 1'b1;
          cmd.push_rej  = 1'b1;
          cmd.push_last = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/dsq_datapath.sv =====
// queue memory, tick counter, walk counters and output register
module dsq_datapath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      action,
  input  logic [dsq_pkg::DUR_W-1:0] sleep_ticks,
  input  logic [dsq_pkg::PRI_W-1:0] priority_req,
  input  logic [dsq_pkg::TID_W-1:0] thread_id,
  input  dsq_pkg::dsq_cmd_t         cmd,
  output dsq_pkg::dsq_sts_t         sts,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      event_res,
  output logic [dsq_pkg::TID_W-1:0] woken_id,
  output logic                      last
);
  import dsq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W:0]     DEPTH_X = (IDX_W + 1)'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0]   DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [NRES_W-1:0]  MAX_C   = NRES_W'(MAX_RESULTS);

  function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
    logic [IDX_W:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DEPTH_X) begin
      s = s - DEPTH_X;
    end
    return s[IDX_W-1:0];
  endfunction

  entry_t             mem [QUEUE_DEPTH];
  entry_t             rd_data;
  entry_t             new_ent;
  deadline_t          tick_count;
  logic [IDX_W-1:0]   head;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   walk;
  logic [NRES_W-1:0]  nrel;
  logic               pend_valid;
  logic [TID_W-1:0]   pend_id;

  logic [CNT_W-1:0]   walk_m1;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;
  logic [DL_W:0]      dl_sum;
  deadline_t          dl_sat;

  assign walk_m1 = walk - CNT_W'(1);
  assign rd_addr = cmd.rd_head ? head : wrap_idx(head, walk_m1[IDX_W-1:0]);
  assign wr_addr = wrap_idx(head, walk[IDX_W-1:0]);
  assign wr_data = cmd.wr_new ? new_ent : rd_data;

  // saturating deadline
  assign dl_sum = {1'b0, tick_count} + (DL_W + 1)'(sleep_ticks);
  assign dl_sat = dl_sum[DL_W] ? DL_MAX : dl_sum[DL_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      new_ent.deadline <= dl_sat;
      new_ent.prio     <= priority_req;
      new_ent.owner    <= thread_id;
      walk             <= count;
      nrel             <= '0;
    end else begin
      if (cmd.walk_dec) begin
        walk <= walk_m1;
      end
      if (cmd.pop) begin
        nrel <= nrel + NRES_W'(1);
      end
    end
    if (cmd.pend_load) begin
      pend_id <= rd_data.owner;
    end
    if (cmd.push) begin
      event_res <= cmd.push_rej ? EV_REJECT : EV_WOKEN;
      woken_id  <= cmd.push_rej ? new_ent.owner : pend_id;
      last      <= cmd.push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      head       <= '0;
      count      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.accept && action == ACT_TICK) begin
        tick_count <= tick_count + DL_W'(1);
      end
      if (cmd.count_inc) begin
        count <= count + CNT_W'(1);
      end else if (cmd.pop) begin
        count <= count - CNT_W'(1);
        head  <= wrap_idx(head, IDX_W'(1));
      end
      if (cmd.pend_load) begin
        pend_valid <= 1'b1;
      end else if (cmd.pend_clear) begin
        pend_valid <= 1'b0;
      end
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.is_sleep    = (action == ACT_SLEEP);
    sts.dur_zero    = (sleep_ticks == '0);
    sts.full        = (count == DEPTH_C);
    sts.walk_zero   = (walk == '0);
    sts.goes_before = (new_ent.deadline < rd_data.deadline) ||
                      ((new_ent.deadline == rd_data.deadline) &&
                       (new_ent.prio > rd_data.prio));
    sts.due         = (rd_data.deadline <= tick_count);
    sts.pend_valid  = pend_valid;
    sts.out_free    = !out_valid || out_ready;
    sts.tick_stop   = (count == '0) || (nrel == MAX_C);
  end

endmodule

// ===== sv/deadline_sleep_queue.sv =====
// sleep item: ignored if its duration is zero, else an insert walk over the single-port queue memory
// that reads and shifts up each queued entry the new one goes before; a rejected item may wait for the output
// tick item: reads and checks the head entry for each release and may wait for the output, at most 16 per tick
// one item in flight at a time; the output register lets the next item in while a result waits
// reset clears the tick counter, queue fill and output register; queue memory is not cleared
module deadline_sleep_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  dsq_req_if.sink   req,
  dsq_rsp_if.source rsp
);
  import dsq_pkg::*;

  dsq_cmd_t cmd;
  dsq_sts_t sts;

  dsq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dsq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .action       (req.action),
    .sleep_ticks  (req.sleep_ticks),
    .priority_req (req.priority_req),
    .thread_id    (req.thread_id),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .event_res    (rsp.event_res),
    .woken_id     (rsp.woken_id),
    .last         (rsp.last)
  );

endmodule

// ===== sv/dsq_checker.sv =====
// port-level checks for the deadline sleep queue
module dsq_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_valid,
  input logic                      req_ready,
  input logic                      req_action,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic                      rsp_event_res,
  input logic [dsq_pkg::TID_W-1:0] rsp_woken_id,
  input logic                      rsp_last
);
  import dsq_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_woken_id) && $stable(rsp_last))
    else $error("response dropped or changed while stalled");

  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_event_res == EV_REJECT |-> rsp_last)
    else $error("reject not marked as final result");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_action == ACT_TICK |=> !req_ready)
    else $error("tick item did not start a release walk");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

endmodule

bind deadline_sleep_queue dsq_checker u_dsq_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .req_action    (req.action),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_event_res (rsp.event_res),
  .rsp_woken_id  (rsp.woken_id),
  .rsp_last      (rsp.last)
);
